// ----- sv/assert_macros.svh -----
// assertion helpers for the rtl (included by record_list_opcode_parser_unit.sv)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define RLOP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// condition must never be true out of reset
`define RLOP_NEVER(label, cond, msg) \
    `RLOP_ASSERT(label, !(cond), msg)

`endif

// ----- sv/rlop_pkg.sv -----
package rlop_pkg;

    // input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       list_start;
    } in_item_t;

    // result item
    typedef struct packed {
        logic [3:0]  field_kind;
        logic [7:0]  slot;
        logic [15:0] field_value;
        logic [15:0] record_number;
        logic        list_done;
    } out_item_t;

    // field kinds
    localparam logic [3:0] KIND_TYPE        = 4'd0;
    localparam logic [3:0] KIND_MODEL_COUNT = 4'd1;
    localparam logic [3:0] KIND_MODEL_ID    = 4'd2;
    localparam logic [3:0] KIND_DISABLE     = 4'd3;
    localparam logic [3:0] KIND_RECOL_SRC   = 4'd4;
    localparam logic [3:0] KIND_RECOL_DST   = 4'd5;
    localparam logic [3:0] KIND_HEAD        = 4'd6;
    localparam logic [3:0] KIND_RECORD_END  = 4'd7;
    localparam logic [3:0] KIND_EMPTY_LIST  = 4'd8;
    localparam logic [3:0] KIND_UNKNOWN     = 4'd9;

    // opcodes
    localparam logic [7:0] OP_END     = 8'd0;
    localparam logic [7:0] OP_TYPE    = 8'd1;
    localparam logic [7:0] OP_MODELS  = 8'd2;
    localparam logic [7:0] OP_DISABLE = 8'd3;
    localparam logic [7:0] OP_SRC_LO  = 8'd40;
    localparam logic [7:0] OP_SRC_HI  = 8'd49;
    localparam logic [7:0] OP_DST_LO  = 8'd50;
    localparam logic [7:0] OP_DST_HI  = 8'd59;
    localparam logic [7:0] OP_HEAD_LO = 8'd60;
    localparam logic [7:0] OP_HEAD_HI = 8'd69;

    // parser phases
    typedef enum logic [8:0] {
        PH_WAIT     = 9'b000000001,
        PH_CNT_LO   = 9'b000000010,
        PH_OPCODE   = 9'b000000100,
        PH_TYPE     = 9'b000001000,
        PH_MCOUNT   = 9'b000010000,
        PH_MODEL_HI = 9'b000100000,
        PH_MODEL_LO = 9'b001000000,
        PH_VAL_HI   = 9'b010000000,
        PH_VAL_LO   = 9'b100000000
    } phase_t;

endpackage

// ----- sv/record_list_opcode_parser_unit.sv -----
// channel | ports                     | payload
// input   | s_valid, s_ready, s_item  | rlop_pkg::in_item_t  (data_byte, list_start)
// result  | m_valid, m_ready, m_item  | rlop_pkg::out_item_t (kind, slot, value, record, done)
//
// one byte per cycle while the result is taken: a byte is held in the input register,
// then the parser step writes its result into the result register, which drives m_;
// throughput is set by the single parser step per cycle.
// aresetn (synchronous, active low) returns the parser to waiting for a list start.
// a stalled result blocks the parser step only; the input register still takes
// one more byte while the result waits.
`include "assert_macros.svh"

module record_list_opcode_parser_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  rlop_pkg::in_item_t   s_item,
    output logic                 m_valid,
    input  logic                 m_ready,
    output rlop_pkg::out_item_t  m_item
);

    // input register
    logic                in_valid_reg;
    rlop_pkg::in_item_t  in_item_reg;

    // result register
    logic                out_valid_reg;
    rlop_pkg::out_item_t out_item_reg;

    // parser state
    rlop_pkg::phase_t phase_reg, phase_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  hold_reg, hold_next;
    logic [7:0]  model_total_reg, model_total_next;
    logic [7:0]  model_index_reg, model_index_next;
    logic [15:0] records_left_reg, records_left_next;
    logic [15:0] record_counter_reg, record_counter_next;

    logic                advance;
    logic                emit;
    rlop_pkg::out_item_t out_next;
    logic [7:0]          b;
    logic [15:0]         word;
    logic [15:0]         left_dec;
    logic [7:0]          index_inc;

    // handshake: parser steps when an item is held and the result slot is free or being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

    assign b         = in_item_reg.data_byte;
    assign word      = {hold_reg, b};
    assign left_dec  = records_left_reg - 16'd1;
    assign index_inc = model_index_reg + 8'd1;

    // one parser step
    always_comb begin
        phase_next          = phase_reg;
        opcode_next         = opcode_reg;
        hold_next           = hold_reg;
        model_total_next    = model_total_reg;
        model_index_next    = model_index_reg;
        records_left_next   = records_left_reg;
        record_counter_next = record_counter_reg;
        emit                = 1'b0;
        out_next            = '0;
        out_next.record_number = record_counter_reg;

        if (in_item_reg.list_start) begin
            hold_next  = b;
            phase_next = rlop_pkg::PH_CNT_LO;
        end else begin
            unique case (phase_reg)
                rlop_pkg::PH_CNT_LO: begin
                    record_counter_next    = '0;
                    records_left_next      = word;
                    out_next.record_number = '0;
                    if (word == 16'd0) begin
                        phase_next          = rlop_pkg::PH_WAIT;
                        emit                = 1'b1;
                        out_next.field_kind = rlop_pkg::KIND_EMPTY_LIST;
                        out_next.list_done  = 1'b1;
                    end else begin
                        phase_next = rlop_pkg::PH_OPCODE;
                    end
                end
                rlop_pkg::PH_OPCODE: begin
                    priority if (b == rlop_pkg::OP_END) begin
                        records_left_next   = left_dec;
                        emit                = 1'b1;
                        out_next.field_kind = rlop_pkg::KIND_RECORD_END;
                        if (left_dec == 16'd0) begin
                            phase_next         = rlop_pkg::PH_WAIT;
                            out_next.list_done = 1'b1;
                        end else begin
                            record_counter_next = record_counter_reg + 16'd1;
                        end
                    end else if (b == rlop_pkg::OP_TYPE) begin
                        phase_next = rlop_pkg::PH_TYPE;
                    end else if (b == rlop_pkg::OP_MODELS) begin
                        phase_next = rlop_pkg::PH_MCOUNT;
                    end else if (b == rlop_pkg::OP_DISABLE) begin
                        emit                 = 1'b1;
                        out_next.field_kind  = rlop_pkg::KIND_DISABLE;
                        out_next.field_value = 16'd1;
                    end else if (b >= rlop_pkg::OP_SRC_LO && b <= rlop_pkg::OP_HEAD_HI) begin
                        opcode_next = b;
                        phase_next  = rlop_pkg::PH_VAL_HI;
                    end else begin
                        phase_next           = rlop_pkg::PH_WAIT;
                        emit                 = 1'b1;
                        out_next.field_kind  = rlop_pkg::KIND_UNKNOWN;
                        out_next.field_value = {8'd0, b};
                        out_next.list_done   = 1'b1;
                    end
                end
                rlop_pkg::PH_TYPE: begin
                    phase_next           = rlop_pkg::PH_OPCODE;
                    emit                 = 1'b1;
                    out_next.field_kind  = rlop_pkg::KIND_TYPE;
                    out_next.field_value = {8'd0, b};
                end
                rlop_pkg::PH_MCOUNT: begin
                    model_total_next     = b;
                    model_index_next     = '0;
                    phase_next           = (b == 8'd0) ? rlop_pkg::PH_OPCODE
                                                       : rlop_pkg::PH_MODEL_HI;
                    emit                 = 1'b1;
                    out_next.field_kind  = rlop_pkg::KIND_MODEL_COUNT;
                    out_next.field_value = {8'd0, b};
                end
                rlop_pkg::PH_MODEL_HI: begin
                    hold_next  = b;
                    phase_next = rlop_pkg::PH_MODEL_LO;
                end
                rlop_pkg::PH_MODEL_LO: begin
                    model_index_next     = index_inc;
                    phase_next           = (index_inc == model_total_reg) ? rlop_pkg::PH_OPCODE
                                                                          : rlop_pkg::PH_MODEL_HI;
                    emit                 = 1'b1;
                    out_next.field_kind  = rlop_pkg::KIND_MODEL_ID;
                    out_next.slot        = model_index_reg;
                    out_next.field_value = word;
                end
                rlop_pkg::PH_VAL_HI: begin
                    hold_next  = b;
                    phase_next = rlop_pkg::PH_VAL_LO;
                end
                rlop_pkg::PH_VAL_LO: begin
                    phase_next           = rlop_pkg::PH_OPCODE;
                    emit                 = 1'b1;
                    out_next.field_value = word;
                    priority if (opcode_reg < rlop_pkg::OP_DST_LO) begin
                        out_next.field_kind = rlop_pkg::KIND_RECOL_SRC;
                        out_next.slot       = opcode_reg - rlop_pkg::OP_SRC_LO;
                    end else if (opcode_reg < rlop_pkg::OP_HEAD_LO) begin
                        out_next.field_kind = rlop_pkg::KIND_RECOL_DST;
                        out_next.slot       = opcode_reg - rlop_pkg::OP_DST_LO;
                    end else begin
                        out_next.field_kind = rlop_pkg::KIND_HEAD;
                        out_next.slot       = opcode_reg - rlop_pkg::OP_HEAD_LO;
                    end
                end
                default: begin
                    // waiting for a list start: byte dropped
                    phase_next = rlop_pkg::PH_WAIT;
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
    end

    // parser state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg          <= rlop_pkg::PH_WAIT;
            opcode_reg         <= '0;
            hold_reg           <= '0;
            model_total_reg    <= '0;
            model_index_reg    <= '0;
            records_left_reg   <= '0;
            record_counter_reg <= '0;
        end else if (advance) begin
            phase_reg          <= phase_next;
            opcode_reg         <= opcode_next;
            hold_reg           <= hold_next;
            model_total_reg    <= model_total_next;
            model_index_reg    <= model_index_next;
            records_left_reg   <= records_left_next;
            record_counter_reg <= record_counter_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= emit;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance && emit) begin
            out_item_reg <= out_next;
        end
    end

    // checks
    `RLOP_ASSERT(a_done_to_wait,
        (advance && emit && out_next.list_done) |=> (phase_reg == rlop_pkg::PH_WAIT),
        "list end did not return parser to wait")
    `RLOP_ASSERT(a_emit_shows, (advance && emit) |=> out_valid_reg,
        "emitted item not shown on result register")
    `RLOP_NEVER(a_no_overwrite, in_valid_reg && !advance && s_ready,
        "input register overwritten while held")

endmodule

// ----- test/tb_record_list_opcode_parser_unit.sv -----
module tb_record_list_opcode_parser_unit;
    import rlop_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 16;
    localparam int PHASE_BYTES  = 120;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    record_list_opcode_parser_unit uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    // clock
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // byte stream waiting to go out, decoded fields waiting to come back
    in_item_t  byte_q[$];
    out_item_t field_q[$];
    out_item_t want_field;

    int n_errors       = 0;
    int n_sent         = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;

    // parser state mirror
    phase_t      prs_phase   = PH_WAIT;
    logic [7:0]  hold_byte   = '0;
    logic [7:0]  cur_opcode  = '0;
    logic [7:0]  model_total = '0;
    logic [7:0]  model_idx   = '0;
    logic [15:0] recs_left   = '0;
    logic [15:0] rec_num     = '0;

    task automatic push_field(input logic [3:0] kind, input logic [7:0] slot_no,
                              input logic [15:0] value, input logic [15:0] rec,
                              input logic done);
        out_item_t f;
        f.field_kind    = kind;
        f.slot          = slot_no;
        f.field_value   = value;
        f.record_number = rec;
        f.list_done     = done;
        field_q.push_back(f);
    endtask

    // advance the parser mirror by one accepted byte
    task automatic parse_byte(input in_item_t it);
        logic [7:0]  b;
        logic [15:0] word;
        b    = it.data_byte;
        word = {hold_byte, b};
        if (it.list_start) begin
            hold_byte = b;
            prs_phase = PH_CNT_LO;
        end else begin
            case (prs_phase)
                PH_CNT_LO: begin
                    rec_num   = '0;
                    recs_left = word;
                    if (word == 16'd0) begin
                        prs_phase = PH_WAIT;
                        push_field(KIND_EMPTY_LIST, 8'd0, 16'd0, 16'd0, 1'b1);
                    end else begin
                        prs_phase = PH_OPCODE;
                    end
                end
                PH_OPCODE: begin
                    if (b == OP_END) begin
                        recs_left = recs_left - 16'd1;
                        if (recs_left == 16'd0) begin
                            prs_phase = PH_WAIT;
                            push_field(KIND_RECORD_END, 8'd0, 16'd0, rec_num, 1'b1);
                        end else begin
                            push_field(KIND_RECORD_END, 8'd0, 16'd0, rec_num, 1'b0);
                            rec_num = rec_num + 16'd1;
                        end
                    end else if (b == OP_TYPE) begin
                        prs_phase = PH_TYPE;
                    end else if (b == OP_MODELS) begin
                        prs_phase = PH_MCOUNT;
                    end else if (b == OP_DISABLE) begin
                        push_field(KIND_DISABLE, 8'd0, 16'd1, rec_num, 1'b0);
                    end else if (b >= OP_SRC_LO && b <= OP_HEAD_HI) begin
                        cur_opcode = b;
                        prs_phase  = PH_VAL_HI;
                    end else begin
                        // unknown opcode ends the list
                        prs_phase = PH_WAIT;
                        push_field(KIND_UNKNOWN, 8'd0, {8'd0, b}, rec_num, 1'b1);
                    end
                end
                PH_TYPE: begin
                    prs_phase = PH_OPCODE;
                    push_field(KIND_TYPE, 8'd0, {8'd0, b}, rec_num, 1'b0);
                end
                PH_MCOUNT: begin
                    model_total = b;
                    model_idx   = '0;
                    prs_phase   = (b == 8'd0) ? PH_OPCODE : PH_MODEL_HI;
                    push_field(KIND_MODEL_COUNT, 8'd0, {8'd0, b}, rec_num, 1'b0);
                end
                PH_MODEL_HI: begin
                    hold_byte = b;
                    prs_phase = PH_MODEL_LO;
                end
                PH_MODEL_LO: begin
                    push_field(KIND_MODEL_ID, model_idx, word, rec_num, 1'b0);
                    model_idx = model_idx + 8'd1;
                    prs_phase = (model_idx == model_total) ? PH_OPCODE : PH_MODEL_HI;
                end
                PH_VAL_HI: begin
                    hold_byte = b;
                    prs_phase = PH_VAL_LO;
                end
                PH_VAL_LO: begin
                    prs_phase = PH_OPCODE;
                    if (cur_opcode <= OP_SRC_HI)
                        push_field(KIND_RECOL_SRC, cur_opcode - OP_SRC_LO, word, rec_num, 1'b0);
                    else if (cur_opcode <= OP_DST_HI)
                        push_field(KIND_RECOL_DST, cur_opcode - OP_DST_LO, word, rec_num, 1'b0);
                    else
                        push_field(KIND_HEAD, cur_opcode - OP_HEAD_LO, word, rec_num, 1'b0);
                end
                default: begin
                end
            endcase
        end
    endtask

    // stream building
    task automatic send(input logic [7:0] b, input logic start);
        in_item_t it;
        it.data_byte  = b;
        it.list_start = start;
        byte_q.push_back(it);
        n_sent++;
    endtask

    task automatic send_word(input logic [15:0] w);
        send(w[15:8], 1'b0);
        send(w[7:0], 1'b0);
    endtask

    task automatic gen_record();
        int n_ops;
        int n_models;
        logic [7:0] op;
        n_ops = $urandom_range(4);
        repeat (n_ops) begin
            case ($urandom_range(3))
                0: begin
                    send(OP_TYPE, 1'b0);
                    send(8'($urandom_range(255)), 1'b0);
                end
                1: begin
                    n_models = ($urandom_range(9) == 0) ? $urandom_range(12) : $urandom_range(3);
                    send(OP_MODELS, 1'b0);
                    send(8'(n_models), 1'b0);
                    repeat (n_models) send_word(16'($urandom_range(65535)));
                end
                2: send(OP_DISABLE, 1'b0);
                default: begin
                    op = 8'($urandom_range(OP_HEAD_HI, OP_SRC_LO));
                    send(op, 1'b0);
                    send_word(16'($urandom_range(65535)));
                end
            endcase
        end
        send(OP_END, 1'b0);
    endtask

    // one list, mostly well formed, sometimes broken
    task automatic gen_list();
        int roll;
        int n_recs;
        logic [15:0] count;
        logic [7:0] op;
        roll   = $urandom_range(99);
        n_recs = (roll < 5) ? 0 : $urandom_range(4, 1);
        count  = 16'(n_recs);
        // oversized count: the next list start cuts this list short
        if (roll >= 96)
            count = 16'($urandom_range(65535, 256));
        send(count[15:8], 1'b1);
        send(count[7:0], 1'b0);
        for (int r = 0; r < n_recs; r++) begin
            roll = $urandom_range(99);
            if (roll < 4) begin
                op = 8'($urandom_range(255, 4));
                if (op >= OP_SRC_LO && op <= OP_HEAD_HI)
                    op = op + 8'd30;
                send(op, 1'b0);
                repeat ($urandom_range(2)) send(8'($urandom_range(255)), 1'b0);
                return;
            end
            if (roll < 7) begin
                // stop inside a model id list
                send(OP_MODELS, 1'b0);
                send(8'd3, 1'b0);
                send(8'($urandom_range(255)), 1'b0);
                return;
            end
            gen_record();
        end
        // trailing bytes after a complete list are ignored
        if ($urandom_range(99) < 15)
            repeat ($urandom_range(3, 1)) send(8'($urandom_range(255)), 1'b0);
    endtask

    // driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready)
                parse_byte(s_item);
            if (!s_valid || s_ready) begin
                if (byte_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    s_valid <= 1'b1;
                    s_item  <= byte_q.pop_front();
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            $display("%0t %s expected %0h actual %0h", $time, name, want, got);
            n_errors++;
        end
    endtask

    // monitor
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (field_q.size() == 0) begin
                    $display("%0t unexpected item expected none actual %h", $time, m_item);
                    n_errors++;
                end else begin
                    want_field = field_q.pop_front();
                    check_field("field_kind", 16'(want_field.field_kind),
                                16'(m_item.field_kind));
                    check_field("slot", 16'(want_field.slot), 16'(m_item.slot));
                    check_field("field_value", want_field.field_value, m_item.field_value);
                    check_field("record_number", want_field.record_number,
                                m_item.record_number);
                    check_field("list_done", 16'(want_field.list_done),
                                16'(m_item.list_done));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic wait_drained();
        while (byte_q.size() != 0 || s_valid || field_q.size() != 0)
            @(posedge aclk);
    endtask

    // stimulus
    initial begin
        int goal;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // byte before any list start
        send(8'hFF, 1'b0);
        // empty list, then a stray byte
        send(8'h00, 1'b1);
        send(8'h00, 1'b0);
        send(OP_END, 1'b0);
        // largest count, dropped by the next list start
        send(8'hFF, 1'b1);
        send(8'hFF, 1'b0);
        send(OP_TYPE, 1'b0);
        // two records covering every opcode
        send(8'h00, 1'b1);
        send(8'h02, 1'b0);
        send(OP_TYPE, 1'b0);
        send(8'hFF, 1'b0);
        send(OP_MODELS, 1'b0);
        send(8'd2, 1'b0);
        send_word(16'hFFFF);
        send_word(16'h0000);
        send(OP_DISABLE, 1'b0);
        send(OP_SRC_LO, 1'b0);
        send_word(16'h1234);
        send(OP_DST_HI, 1'b0);
        send_word(16'hABCD);
        send(OP_HEAD_HI, 1'b0);
        send_word(16'h0001);
        send(OP_END, 1'b0);
        // zero model count, then unknown opcode and an ignored byte
        send(OP_MODELS, 1'b0);
        send(8'd0, 1'b0);
        send(8'hFF, 1'b0);
        send(OP_DISABLE, 1'b0);
        wait_drained();

        // random lists under each flow-control mix
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
                default: begin send_idle_pct = 16; recv_stall_pct = 16; end
            endcase
            goal = n_sent + PHASE_BYTES;
            while (n_sent < goal)
                gen_list();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (n_errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
